// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C EEPROM master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes on the input side
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  // Completion status codes
  localparam logic [2:0] StatOk       = 3'd0;
  localparam logic [2:0] StatDevNack  = 3'd1;
  localparam logic [2:0] StatWordNack = 3'd2;
  localparam logic [2:0] StatDataNack = 3'd3;
  localparam logic [2:0] StatRdAdNack = 3'd4;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  // One timing slot request
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] word_addr;
    logic [7:0] length;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // Bus levels and status for one slot
  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       byte_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

// ----- rtl/i2cm_core.sv -----
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer state and next-slot logic; advances one slot per step_i.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  input  logic           step_i,
  input  i2cm_pkg::item_t item_i,
  output i2cm_pkg::res_t  res_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhStart, PhRstart,
    PhSendDevw, PhAckDevw, PhSendWord, PhAckWord,
    PhSendData, PhAckData, PhSendDevr, PhAckDevr,
    PhRecv, PhMack, PhStop
  } phase_e;

  phase_e     phase_q, phase_d, ph_e;
  logic [1:0] slot_q, slot_d, ss_e;
  logic [2:0] bit_q, bit_d, bi_e;
  logic [7:0] shift_q, shift_d, sh_e;
  logic [8:0] left_q, left_d, bl_e, bl_dec;
  logic       rmode_q, rmode_d, rm_e;
  logic [7:0] sword_q, sword_d, sw_e;
  logic [6:0] dev_q;
  logic       begin_c;
  logic [1:0] stop_s;
  logic [7:0] rx_shift;

  always_comb begin
    begin_c = (phase_q == PhIdle) && ((item_i.cmd == CmdWrite) || (item_i.cmd == CmdRead));
    ph_e = begin_c ? PhStart : phase_q;
    ss_e = begin_c ? 2'd0 : slot_q;
    bi_e = begin_c ? 3'd0 : bit_q;
    rm_e = begin_c ? (item_i.cmd == CmdRead) : rmode_q;
    sw_e = begin_c ? item_i.word_addr : sword_q;
    bl_e = begin_c ? (((item_i.cmd == CmdRead) && (item_i.length == 8'd0)) ? 9'd256
                                                                           : {1'b0, item_i.length})
                   : left_q;
    sh_e = shift_q;
    bl_dec = (bl_e != 9'd0) ? bl_e - 9'd1 : bl_e;
    rx_shift = {shift_q[6:0], item_i.sda_in};
    stop_s = (slot_q > 2'd2) ? 2'd2 : slot_q;

    phase_d = ph_e;
    slot_d  = ss_e;
    bit_d   = bi_e;
    shift_d = sh_e;
    left_d  = bl_e;
    rmode_d = rm_e;
    sword_d = sw_e;

    res_o = '0;
    res_o.scl = 1'b1;

    case (ph_e)
      PhIdle: ;
      PhStart, PhRstart: begin
        res_o.busy_res = 1'b1;
        res_o.scl      = (ss_e == 2'd1) || (ss_e == 2'd2);
        res_o.sda_low  = ss_e[1];
        if (ss_e == 2'd3) begin
          phase_d = (ph_e == PhStart) ? PhSendDevw : PhSendDevr;
          shift_d = {dev_q, (ph_e == PhRstart)};
          bit_d   = 3'd0;
          slot_d  = 2'd0;
        end else begin
          slot_d = ss_e + 2'd1;
        end
      end
      PhSendDevw, PhSendWord, PhSendData, PhSendDevr: begin
        res_o.busy_res = 1'b1;
        if ((ph_e == PhSendData) && (bi_e == 3'd0) && (ss_e == 2'd0)) begin
          sh_e = item_i.write_byte;
          res_o.byte_taken = 1'b1;
        end
        res_o.sda_low = ~sh_e[7];
        res_o.scl     = (ss_e != 2'd0);
        shift_d       = sh_e;
        if (ss_e == 2'd0) begin
          slot_d = 2'd1;
        end else begin
          slot_d  = 2'd0;
          shift_d = {sh_e[6:0], 1'b0};
          bit_d   = bi_e + 3'd1;
          if (bi_e == 3'd7) begin
            case (ph_e)
              PhSendDevw: phase_d = PhAckDevw;
              PhSendWord: phase_d = PhAckWord;
              PhSendData: phase_d = PhAckData;
              default:    phase_d = PhAckDevr;
            endcase
          end
        end
      end
      PhAckDevw, PhAckWord, PhAckData, PhAckDevr: begin
        res_o.busy_res = 1'b1;
        res_o.sda_low  = 1'b0;
        res_o.scl      = (ss_e != 2'd0);
        if (ss_e == 2'd0) begin
          slot_d = 2'd1;
        end else begin
          slot_d = 2'd0;
          if (item_i.sda_in) begin
            // slave did not acknowledge: finish here with no stop
            res_o.done_res = 1'b1;
            case (ph_e)
              PhAckDevw: res_o.status = StatDevNack;
              PhAckWord: res_o.status = StatWordNack;
              PhAckData: res_o.status = StatDataNack;
              default:   res_o.status = StatRdAdNack;
            endcase
            phase_d = PhIdle;
          end else begin
            case (ph_e)
              PhAckDevw: begin
                phase_d = PhSendWord;
                shift_d = sw_e;
                bit_d   = 3'd0;
              end
              PhAckWord: begin
                if (rm_e) begin
                  phase_d = PhRstart;
                end else if (bl_e == 9'd0) begin
                  phase_d = PhStop;
                end else begin
                  phase_d = PhSendData;
                  shift_d = 8'd0;
                  bit_d   = 3'd0;
                end
              end
              PhAckData: begin
                left_d = bl_dec;
                if (bl_dec == 9'd0) begin
                  phase_d = PhStop;
                end else begin
                  phase_d = PhSendData;
                  shift_d = 8'd0;
                  bit_d   = 3'd0;
                end
              end
              default: begin
                phase_d = PhRecv;
                shift_d = 8'd0;
                bit_d   = 3'd0;
              end
            endcase
          end
        end
      end
      PhRecv: begin
        res_o.busy_res = 1'b1;
        res_o.scl      = (ss_e != 2'd0);
        if (ss_e == 2'd0) begin
          slot_d = 2'd1;
        end else begin
          slot_d  = 2'd0;
          shift_d = rx_shift;
          bit_d   = bi_e + 3'd1;
          if (bi_e == 3'd7) begin
            res_o.read_byte  = rx_shift;
            res_o.read_valid = 1'b1;
            left_d  = bl_dec;
            phase_d = PhMack;
          end
        end
      end
      PhMack: begin
        res_o.busy_res = 1'b1;
        res_o.sda_low  = (bl_e != 9'd0);  // ACK unless this was the last byte
        res_o.scl      = (ss_e != 2'd0);
        if (ss_e == 2'd0) begin
          slot_d = 2'd1;
        end else begin
          slot_d = 2'd0;
          if (bl_e != 9'd0) begin
            phase_d = PhRecv;
            shift_d = 8'd0;
            bit_d   = 3'd0;
          end else begin
            phase_d = PhStop;
          end
        end
      end
      PhStop: begin
        res_o.busy_res = 1'b1;
        res_o.scl      = (stop_s != 2'd0);
        res_o.sda_low  = (stop_s != 2'd2);
        if (stop_s == 2'd2) begin
          res_o.done_res = 1'b1;
          slot_d  = 2'd0;
          phase_d = PhIdle;
        end else begin
          slot_d = stop_s + 2'd1;
        end
      end
      default: begin
        phase_d = PhIdle;
        slot_d  = 2'd0;
        bit_d   = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      slot_q  <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      left_q  <= 9'd0;
      rmode_q <= 1'b0;
      sword_q <= 8'd0;
      dev_q   <= 7'd80;
    end else begin
      if (cfg_we_i) begin
        dev_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        slot_q  <= slot_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        left_q  <= left_d;
        rmode_q <= rmode_d;
        sword_q <= sword_d;
      end
    end
  end

endmodule

// ----- rtl/i2c_eeprom_master_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_eeprom_master_unit
// I2C master for a 24C02-style EEPROM, stepped one bus timing slot per item.
// ----------------------------------------------------------------------------
// Each input transaction is one bus timing slot: a tick, or a begin-write /
// begin-read command, together with the SDA level sampled in that slot. Each
// slot yields exactly one output transaction carrying the SCL level and the
// SDA pull-down to drive, plus byte handshakes and completion status. The
// block sustains one slot per clock while results are taken: an input register
// feeds the slot sequencer, whose result lands in an output register. While a
// result waits downstream the input register takes one more slot, and then
// the input stalls until the waiting result is taken.
// A write sends start, device address + W, word address and `length` data
// bytes (write_byte is consumed in slots flagged byte_taken), then stop. A
// read adds a repeated start and device address + R, then receives `length`
// bytes (0 means 256), ACKing all but the last. A slave NACK ends the
// transaction in the ACK sample slot with an error status and no stop. The
// device address (reset 0x50) may be written only while the block is idle.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // slot requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] word_addr, [15:8] length, [23:16] write_byte, [24] sda_in, [31:25] zero
  input  logic [i2cm_pkg::InDataW-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  // slot results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl, [1] sda_low, [2] byte_taken, [10:3] read_byte, [11] read_valid,
  // [12] busy_res, [13] done_res, [16:14] status, [23:17] zero
  output logic [i2cm_pkg::OutDataW-1:0] m_axis_tdata
);
  import i2cm_pkg::*;

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;
  res_t  step_res;
  logic  step;

  // advance the sequencer when a slot is held and the result register frees up
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd        <= s_axis_tuser;
      in_item_q.word_addr  <= s_axis_tdata[7:0];
      in_item_q.length     <= s_axis_tdata[15:8];
      in_item_q.write_byte <= s_axis_tdata[23:16];
      in_item_q.sda_in     <= s_axis_tdata[24];
    end
    if (step) begin
      out_res_q <= step_res;
    end
  end

  i2cm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (in_item_q),
    .res_o       (step_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.status, out_res_q.done_res, out_res_q.busy_res,
                          out_res_q.read_valid, out_res_q.read_byte, out_res_q.byte_taken,
                          out_res_q.sda_low, out_res_q.scl};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C EEPROM master slot sequencer.
// ----------------------------------------------------------------------------
// Slot requests are driven on the input stream in random bursts. Each accepted
// request goes through a cycle-free model of the sequencer, and the bus slot it
// should produce is queued. Every output transaction is compared, field by
// field, against the oldest queued slot. The stimulus runs whole write and
// read transfers and drives the slave side of the bus: it ACKs or NACKs in
// the ACK sample slots and supplies random read data. A directed opening
// covers the corner cases, and then random transfers follow under random
// device addresses, 0 and 127 among them.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam logic [1:0] CmdSpare = 2'd3;  // undefined code, acts as a tick
  localparam int unsigned RandomSlots = 1850;

  // sequencer phases; each send phase is directly followed by its ACK phase
  typedef enum logic [4:0] {
    PhIdle, PhStart, PhRstart, PhSendDevW, PhAckDevW, PhSendWord, PhAckWord,
    PhSendData, PhAckData, PhSendDevR, PhAckDevR, PhRecv, PhMack, PhStop
  } seq_phase_e;

  // --------------------------------------------------------------------------
  // Slot predictor and result checker
  // --------------------------------------------------------------------------
  class bus_slot_checker;
    seq_phase_e ph;
    logic [1:0] step;
    logic [3:0] bitn;
    logic [7:0] shreg;
    logic [8:0] left;
    logic       rd_mode;
    logic [7:0] word;
    logic [6:0] dev;
    res_t       due_slots[$];
    int         slots_noted;
    int         errors;

    function new();
      ph = PhIdle;
      step = '0;
      bitn = '0;
      shreg = '0;
      left = '0;
      rd_mode = 1'b0;
      word = '0;
      dev = 7'd80;
      slots_noted = 0;
      errors = 0;
    endfunction

    function logic [2:0] nack_code(seq_phase_e p);
      case (p)
        PhAckDevW: return StatDevNack;
        PhAckWord: return StatWordNack;
        PhAckData: return StatDataNack;
        default:   return StatRdAdNack;
      endcase
    endfunction

    // true when the coming slot samples the slave's ACK
    function bit ack_sample();
      return (ph == PhAckDevW || ph == PhAckWord || ph == PhAckData ||
              ph == PhAckDevR) && step != 2'd0;
    endfunction

    function void load_byte(seq_phase_e p, logic [7:0] v);
      ph = p;
      shreg = v;
      bitn = '0;
      step = '0;
    endfunction

    // advance one timing slot and return the bus levels for it
    function res_t next_bus_slot(item_t it);
      res_t r;
      logic [1:0] s;
      r = '0;
      r.scl = 1'b1;
      if (ph == PhIdle && (it.cmd == CmdWrite || it.cmd == CmdRead)) begin
        rd_mode = (it.cmd == CmdRead);
        word = it.word_addr;
        left = (rd_mode && it.length == 8'd0) ? 9'd256 : {1'b0, it.length};
        ph = PhStart;
        step = '0;
        bitn = '0;
      end
      case (ph)
        PhIdle: ;
        PhStart, PhRstart: begin
          r.busy_res = 1'b1;
          r.scl = (step == 2'd1 || step == 2'd2);
          r.sda_low = step[1];
          if (step == 2'd3) begin
            if (ph == PhStart) load_byte(PhSendDevW, {dev, 1'b0});
            else load_byte(PhSendDevR, {dev, 1'b1});
          end else begin
            step = step + 2'd1;
          end
        end
        PhSendDevW, PhSendWord, PhSendData, PhSendDevR: begin
          r.busy_res = 1'b1;
          if (ph == PhSendData && bitn == 4'd0 && step == 2'd0) begin
            shreg = it.write_byte;
            r.byte_taken = 1'b1;
          end
          r.sda_low = ~shreg[7];
          r.scl = (step != 2'd0);
          if (step == 2'd0) begin
            step = 2'd1;
          end else begin
            step = 2'd0;
            shreg = shreg << 1;
            bitn = bitn + 4'd1;
            if (bitn >= 4'd8) begin
              bitn = '0;
              ph = seq_phase_e'(ph + 1);
            end
          end
        end
        PhAckDevW, PhAckWord, PhAckData, PhAckDevR: begin
          r.busy_res = 1'b1;
          r.scl = (step != 2'd0);
          if (step == 2'd0) begin
            step = 2'd1;
          end else begin
            step = 2'd0;
            if (it.sda_in) begin
              r.done_res = 1'b1;
              r.status = nack_code(ph);
              ph = PhIdle;
            end else if (ph == PhAckDevW) begin
              load_byte(PhSendWord, word);
            end else if (ph == PhAckWord) begin
              if (rd_mode) ph = PhRstart;
              else if (left == 9'd0) ph = PhStop;
              else load_byte(PhSendData, 8'd0);
            end else if (ph == PhAckData) begin
              if (left != 9'd0) left = left - 9'd1;
              if (left == 9'd0) ph = PhStop;
              else load_byte(PhSendData, 8'd0);
            end else begin
              load_byte(PhRecv, 8'd0);
            end
          end
        end
        PhRecv: begin
          r.busy_res = 1'b1;
          r.scl = (step != 2'd0);
          if (step == 2'd0) begin
            step = 2'd1;
          end else begin
            step = 2'd0;
            shreg = {shreg[6:0], it.sda_in};
            bitn = bitn + 4'd1;
            if (bitn >= 4'd8) begin
              bitn = '0;
              r.read_byte = shreg;
              r.read_valid = 1'b1;
              if (left != 9'd0) left = left - 9'd1;
              ph = PhMack;
            end
          end
        end
        PhMack: begin
          r.busy_res = 1'b1;
          r.sda_low = (left != 9'd0);
          r.scl = (step != 2'd0);
          if (step == 2'd0) begin
            step = 2'd1;
          end else begin
            step = 2'd0;
            if (left != 9'd0) load_byte(PhRecv, 8'd0);
            else ph = PhStop;
          end
        end
        PhStop: begin
          s = (step > 2'd2) ? 2'd2 : step;
          r.busy_res = 1'b1;
          r.scl = (s != 2'd0);
          r.sda_low = (s != 2'd2);
          if (s == 2'd2) begin
            r.done_res = 1'b1;
            step = '0;
            ph = PhIdle;
          end else begin
            step = s + 2'd1;
          end
        end
        default: begin
          ph = PhIdle;
          step = '0;
          bitn = '0;
        end
      endcase
      return r;
    endfunction

    function void note_request(item_t it);
      due_slots.push_back(next_bus_slot(it));
      slots_noted++;
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_slot(logic [OutDataW-1:0] d);
      res_t want;
      if (due_slots.size() == 0) begin
        errors++;
        $display("%0t: unexpected slot expected none got %0h", $time, d);
        return;
      end
      want = due_slots.pop_front();
      cmp("scl", want.scl, d[0]);
      cmp("sda_low", want.sda_low, d[1]);
      cmp("byte_taken", want.byte_taken, d[2]);
      cmp("read_byte", want.read_byte, d[10:3]);
      cmp("read_valid", want.read_valid, d[11]);
      cmp("busy_res", want.busy_res, d[12]);
      cmp("done_res", want.done_res, d[13]);
      cmp("status", want.status, d[16:14]);
      cmp("pad", 0, d[23:17]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [6:0]          cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // word_addr, length, write_byte, sda_in
  logic [1:0]          s_axis_tuser;   // cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // scl, sda_low, byte_taken, read_byte,
                                       // read_valid, busy, done, status

  bus_slot_checker sb = new();
  int burst_left = 0;

  i2c_eeprom_master_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the handshakes hang
  initial begin
    #5_000_000;
    $display("i2c_eeprom_master_unit: mismatch");
    $finish;
  end

  // Output side: ready follows a rotating 8-bit pattern that is redrawn every
  // segment. Bit 0 is forced high so no pattern stalls for good, and
  // a third of the segments run with no stall at all.
  initial begin
    logic [7:0] pat;
    m_axis_tready <= 1'b0;
    forever begin
      pat = ($urandom_range(2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      repeat ($urandom_range(16, 80)) begin
        @(posedge clk_i);
        m_axis_tready <= pat[0];
        pat = {pat[0], pat[7:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_slot(m_axis_tdata);
  end

  // --------------------------------------------------------------------------
  // Input side drivers
  // --------------------------------------------------------------------------

  // One slot request. Requests go out in bursts, and a short gap with valid
  // low is inserted whenever a burst runs out.
  task automatic push_slot(item_t it);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.sda_in, it.write_byte, it.length, it.word_addr};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(it);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.cmd        = CmdTick;
    it.word_addr  = 8'($urandom);
    it.length     = 8'($urandom);
    it.write_byte = 8'($urandom);
    it.sda_in     = 1'($urandom);
    return it;
  endfunction

  // ticks between transfers; the spare code must also leave the bus idle
  task automatic idle_slots(int n);
    item_t it;
    repeat (n) begin
      it = rand_item();
      it.cmd = $urandom_range(1) ? CmdSpare : CmdTick;
      push_slot(it);
    end
  endtask

  // One whole transfer, acting as the slave on the bus. nack_sel picks an ACK
  // slot to NACK after nack_skip earlier ones of that kind have been ACKed;
  // other ACK slots NACK at nack_pct percent. Write data is fill, or random
  // when fill is negative. noise_pct of the ticks carry a begin or the spare
  // code, which a busy sequencer must ignore.
  task automatic run_transfer(logic [1:0] cmd, logic [7:0] addr, logic [7:0] len,
                              logic [2:0] nack_sel, int nack_skip, int nack_pct,
                              int fill, int noise_pct);
    item_t it;
    int skip;
    skip = nack_skip;
    it = rand_item();
    it.cmd = cmd;
    it.word_addr = addr;
    it.length = len;
    push_slot(it);
    while (sb.ph != PhIdle) begin
      it = rand_item();
      if (fill >= 0) it.write_byte = 8'(fill);
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0:       it.cmd = CmdWrite;
          1:       it.cmd = CmdRead;
          default: it.cmd = CmdSpare;
        endcase
      end
      if (sb.ack_sample()) begin
        if (nack_sel != StatOk && sb.nack_code(sb.ph) == nack_sel) begin
          it.sda_in = (skip == 0);
          skip--;
        end else begin
          it.sda_in = ($urandom_range(99) < nack_pct);
        end
      end
      push_slot(it);
    end
  endtask

  // device address write, only with the sequencer idle and the pipe drained
  task automatic set_device(logic [6:0] v);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.due_slots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.dev = v;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    item_t it;
    int target;
    logic [1:0] cmd;
    logic [7:0] len;
    bit long_run;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CmdTick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle ticks, including the spare code with every field high
    it = rand_item();
    push_slot(it);
    it = '1;
    it.cmd = CmdSpare;
    push_slot(it);

    // zero-length write goes straight from word ACK to stop
    run_transfer(CmdWrite, 8'h00, 8'd0, StatOk, 0, 0, -1, 0);
    run_transfer(CmdWrite, 8'hFF, 8'd1, StatOk, 0, 0, 8'hFF, 0);
    run_transfer(CmdWrite, 8'hA5, 8'd2, StatOk, 0, 0, 8'h00, 30);
    run_transfer(CmdRead, 8'h00, 8'd1, StatOk, 0, 0, -1, 0);
    run_transfer(CmdRead, 8'h5A, 8'd3, StatOk, 0, 0, -1, 30);
    // zero-length read fetches 256 bytes
    run_transfer(CmdRead, 8'h10, 8'd0, StatOk, 0, 0, -1, 0);

    // each NACK point ends the transfer without a stop
    run_transfer(CmdWrite, 8'h01, 8'd3, StatDevNack, 0, 0, -1, 0);
    run_transfer(CmdWrite, 8'h02, 8'd3, StatWordNack, 0, 0, -1, 0);
    run_transfer(CmdWrite, 8'h03, 8'd255, StatDataNack, 2, 0, -1, 0);
    run_transfer(CmdRead, 8'h04, 8'd4, StatWordNack, 0, 0, -1, 0);
    run_transfer(CmdRead, 8'h05, 8'd4, StatRdAdNack, 0, 0, -1, 0);

    // address extremes
    set_device(7'd0);
    run_transfer(CmdWrite, 8'h80, 8'd1, StatOk, 0, 0, -1, 0);
    run_transfer(CmdRead, 8'h81, 8'd2, StatOk, 0, 0, -1, 0);
    set_device(7'd127);
    run_transfer(CmdWrite, 8'h7F, 8'd1, StatOk, 0, 0, -1, 0);
    run_transfer(CmdRead, 8'hFE, 8'd2, StatOk, 0, 0, -1, 0);

    // random transfers
    target = sb.slots_noted + RandomSlots;
    while (sb.slots_noted < target) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       set_device(7'd0);
          1:       set_device(7'd127);
          default: set_device(7'($urandom));
        endcase
      end
      if ($urandom_range(9) == 0) idle_slots($urandom_range(1, 4));
      cmd = $urandom_range(1) ? CmdWrite : CmdRead;
      long_run = (cmd == CmdWrite) && ($urandom_range(15) == 0);
      if (long_run) len = 8'($urandom);
      else if (cmd == CmdRead) len = 8'($urandom_range(1, 4));
      else len = 8'($urandom_range(0, 4));
      // long writes are cut short by a higher NACK rate
      run_transfer(cmd, 8'($urandom), len, StatOk, 0, long_run ? 12 : 4, -1, 5);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.due_slots.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("i2c_eeprom_master_unit: match");
    end else begin
      $display("i2c_eeprom_master_unit: mismatch");
    end
    $finish;
  end

endmodule
